[src/itpf_pkg.sv]
// ----------------------------------------------------------------------------
// itpf_pkg
// Types and constants shared by the idle timeout packet framer.
// ----------------------------------------------------------------------------
package itpf_pkg;

    // request commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // printable ascii window, low bound inclusive, end exclusive
    localparam logic [7:0] PRINT_LOW = 8'h20;
    localparam logic [7:0] PRINT_END = 8'h7F;

    // timeout register reset value
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } itpf_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [5:0]  out_index;
        logic        out_last;
        logic        printable;
        logic [6:0]  packet_length;
        logic        forced_flush;
        logic [31:0] packet_total;
        logic [31:0] byte_total;
    } itpf_out_t;

endpackage

[src/idle_timeout_packet_framer.sv]
// ----------------------------------------------------------------------------
// idle_timeout_packet_framer
// Frames received bytes into packets on line silence or on a full buffer.
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one request per handshake: a received byte or one tick.
//   a byte is written into the packet ram and restarts the idle
//   counter. ticks count idle time while a packet is held.
//   once the idle count reaches timeout_ticks (0 acts as 1), or a byte finds
//   the buffer full (that byte is dropped), the held packet is streamed out
//   on m_* as one result per byte, in arrival order.
//   throughput: one request per cycle while no packet is being sent; s_ready
//   is low while a packet is read out, one ram read per cycle unless m_ready
//   stalls (the single read port of the packet ram sets this).
//   m_ready low freezes the output register and the ram read data; no result
//   is lost. a new request may be taken while the last result still waits.
//   reset (aresetn low, synchronous) empties the packet, clears the counters
//   and totals and loads timeout_ticks with 1000. ram contents are not cleared,
//   only entries below the fill count are ever read. cfg_wr_en writes
//   timeout_ticks at once; the user must assert it only while the block is
//   idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module idle_timeout_packet_framer #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  itpf_pkg::itpf_in_t  s_data,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output itpf_pkg::itpf_out_t m_data,
    // timeout register write
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);

    import itpf_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);       // ram address width
    localparam int FW = $clog2(BUFFER_DEPTH + 1);   // fill count width

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    // control state
    state_t          state_reg, state_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic            receiving_reg, receiving_next;
    logic [15:0]     idle_reg, idle_next;
    logic [31:0]     packets_reg, packets_next;
    logic [31:0]     bytes_reg, bytes_next;
    logic [15:0]     timeout_reg;

    // packet being emitted
    logic [FW-1:0]   em_len_reg, em_len_next;
    logic            em_forced_reg, em_forced_next;
    logic [AW-1:0]   em_idx_reg, em_idx_next;

    // output stage, byte comes from the ram read register
    logic            m_valid_reg, m_valid_next;
    logic [AW-1:0]   out_idx_reg;
    logic            out_last_reg;
    logic [FW-1:0]   out_len_reg;
    logic            out_forced_reg;
    logic [31:0]     out_ptot_reg;
    logic [31:0]     out_btot_reg;

    // ram ports
    logic            wr_en;
    logic            rd_en;
    logic [7:0]      rd_data;

    logic            req_take;
    logic            is_full;
    logic [15:0]     limit;
    logic [15:0]     idle_inc;
    logic            start_emit;
    logic            start_forced;
    logic            rd_last;

    assign s_ready  = (state_reg == ST_IDLE);
    assign req_take = s_valid && s_ready;
    assign is_full  = (fill_reg == FW'(BUFFER_DEPTH));
    assign limit    = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    // saturating idle count, taken on every tick while a packet is held
    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;

    // the ram is written only in idle and read only in emit, so a read
    // never meets a write to the same entry
    assign wr_en = req_take && (s_data.command == CMD_BYTE) && !is_full;

    // issue the next read when the output slot is free or being emptied
    assign rd_en   = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign rd_last = (FW'(FW'(em_idx_reg) + FW'(1)) == em_len_reg);

    always_comb begin
        start_emit   = 1'b0;
        start_forced = 1'b0;
        if (req_take) begin
            case (s_data.command)
                CMD_BYTE: begin
                    if (is_full) begin
                        start_emit   = 1'b1;
                        start_forced = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (receiving_reg && (fill_reg != '0) && (idle_inc >= limit)) begin
                        start_emit = 1'b1;
                    end
                end
                default: begin
                    start_emit = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        receiving_next = receiving_reg;
        idle_next      = idle_reg;
        packets_next   = packets_reg;
        bytes_next     = bytes_reg;
        em_len_next    = em_len_reg;
        em_forced_next = em_forced_reg;
        em_idx_next    = em_idx_reg;
        m_valid_next   = m_valid_reg;

        // result handshake
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (start_emit) begin
                    // latch packet, update totals, empty the buffer
                    em_len_next    = fill_reg;
                    em_forced_next = start_forced;
                    em_idx_next    = '0;
                    packets_next   = packets_reg + 32'd1;
                    bytes_next     = bytes_reg + 32'(fill_reg);
                    fill_next      = '0;
                    receiving_next = 1'b0;
                    idle_next      = 16'd0;
                    state_next     = ST_EMIT;
                end else if (wr_en) begin
                    fill_next      = FW'(fill_reg + FW'(1));
                    receiving_next = 1'b1;
                    idle_next      = 16'd0;
                end else if (req_take && (s_data.command == CMD_TICK)
                             && receiving_reg && (fill_reg != '0)) begin
                    idle_next = idle_inc;
                end
            end
            ST_EMIT: begin
                if (rd_en) begin
                    m_valid_next = 1'b1;
                    em_idx_next  = AW'(em_idx_reg + AW'(1));
                    if (rd_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            receiving_reg <= 1'b0;
            idle_reg      <= 16'd0;
            packets_reg   <= 32'd0;
            bytes_reg     <= 32'd0;
            timeout_reg   <= TIMEOUT_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            receiving_reg <= receiving_next;
            idle_reg      <= idle_next;
            packets_reg   <= packets_next;
            bytes_reg     <= bytes_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        em_len_reg    <= em_len_next;
        em_forced_reg <= em_forced_next;
        em_idx_reg    <= em_idx_next;
        // side fields move with each ram read
        if (rd_en) begin
            out_idx_reg    <= em_idx_reg;
            out_last_reg   <= rd_last;
            out_len_reg    <= em_len_reg;
            out_forced_reg <= em_forced_reg;
            out_ptot_reg   <= packets_reg;
            out_btot_reg   <= bytes_reg;
        end
    end

    itpf_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_packet_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (s_data.data_byte),
        .rd_en   (rd_en),
        .rd_addr (em_idx_reg),
        .rd_data (rd_data)
    );

    // output mapping
    assign m_valid                = m_valid_reg;
    assign m_data.out_byte        = rd_data;
    assign m_data.out_index       = 6'(out_idx_reg);
    assign m_data.out_last        = out_last_reg;
    assign m_data.printable       = (rd_data >= PRINT_LOW) && (rd_data < PRINT_END);
    assign m_data.packet_length   = 7'(out_len_reg);
    assign m_data.forced_flush    = out_forced_reg;
    assign m_data.packet_total    = out_ptot_reg;
    assign m_data.byte_total      = out_btot_reg;

endmodule

[src/itpf_ram.sv]
// ----------------------------------------------------------------------------
// itpf_ram
// Generic simple dual-port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
module itpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while rd_en is low
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[tb/idle_timeout_packet_framer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_timeout_packet_framer_tb
// Drives bytes and ticks into the framer and checks every emitted result
// against an in-bench prediction of packet contents, flags and running totals.
// Covers timeout and full-buffer flushes, several timeout settings including
// the extremes, random request gaps, result stalls and one long result hold.
// ----------------------------------------------------------------------------
module idle_timeout_packet_framer_tb;

    import itpf_pkg::*;

    localparam int  RAM_DEPTH = 64;
    localparam int  SETTLE_CYCLES = 4;
    localparam int  LONG_HOLD_CYCLES = 300;
    localparam time LIMIT_NS = 10_000_000;

    // prediction of the framer: held packet, idle count, totals, and the
    // queue of results still owed by the block
    class frame_scoreboard;
        itpf_out_t   expected_q[$];
        logic [7:0]  held_bytes [RAM_DEPTH];
        int unsigned held_count;
        bit          packet_open;
        logic [15:0] quiet_ticks;
        logic [15:0] idle_limit;
        logic [31:0] packets_sent;
        logic [31:0] bytes_sent;
        int          errors;

        function new();
            held_count   = 0;
            packet_open  = 1'b0;
            quiet_ticks  = '0;
            idle_limit   = TIMEOUT_RESET;
            packets_sent = '0;
            bytes_sent   = '0;
            errors       = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void queue_packet(bit forced);
            itpf_out_t r;
            int        k;
            packets_sent += 32'd1;
            bytes_sent   += 32'(held_count);
            for (k = 0; k < held_count; k++) begin
                r.out_byte      = held_bytes[k];
                r.out_index     = 6'(k);
                r.out_last      = (k == held_count - 1);
                r.printable     = (held_bytes[k] >= PRINT_LOW) && (held_bytes[k] < PRINT_END);
                r.packet_length = 7'(held_count);
                r.forced_flush  = forced;
                r.packet_total  = packets_sent;
                r.byte_total    = bytes_sent;
                expected_q.push_back(r);
            end
            held_count  = 0;
            packet_open = 1'b0;
            quiet_ticks = '0;
        endfunction

        // returns 1 when the request had any effect on the framer
        function bit note_request(itpf_in_t req);
            logic [15:0] limit;
            limit = (idle_limit == 16'd0) ? 16'd1 : idle_limit;
            if (req.command == CMD_BYTE) begin
                if (held_count < RAM_DEPTH) begin
                    held_bytes[held_count] = req.data_byte;
                    held_count++;
                    packet_open = 1'b1;
                    quiet_ticks = '0;
                end else begin
                    queue_packet(1'b1);
                end
                return 1'b1;
            end
            if (!(packet_open && held_count > 0))
                return 1'b0;
            if (quiet_ticks != 16'hFFFF)
                quiet_ticks++;
            if (quiet_ticks >= limit)
                queue_packet(1'b0);
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(itpf_out_t got);
            itpf_out_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            compare_field("out_index", 32'(want.out_index), 32'(got.out_index));
            compare_field("out_last", 32'(want.out_last), 32'(got.out_last));
            compare_field("printable", 32'(want.printable), 32'(got.printable));
            compare_field("packet_length", 32'(want.packet_length), 32'(got.packet_length));
            compare_field("forced_flush", 32'(want.forced_flush), 32'(got.forced_flush));
            compare_field("packet_total", want.packet_total, got.packet_total);
            compare_field("byte_total", want.byte_total, got.byte_total);
        endfunction
    endclass

    // clock, reset and every block input start at known values
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    itpf_in_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    itpf_out_t   m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    frame_scoreboard sb = new();

    // idling controls shared between the request and result sides
    bit tx_gaps      = 1'b0;
    bit rx_stalls    = 1'b0;
    bit hold_request = 1'b0;
    int counted      = 0;

    idle_timeout_packet_framer #(
        .BUFFER_DEPTH(RAM_DEPTH)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // result side: free running, random stall bursts, or one long hold
    // while the request side keeps offering so the block backs up
    initial begin : result_sink
        int hold_left;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                for (hold_left = LONG_HOLD_CYCLES; hold_left > 0; hold_left--)
                    @(posedge aclk);
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // every accepted result is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // offer one request, optionally after a gap, and wait for the handshake;
    // returns in the step of acceptance without touching s_valid
    task automatic send_request(input logic cmd, input logic [7:0] value);
        itpf_in_t req;
        req.command   = cmd;
        req.data_byte = value;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        if (sb.note_request(req))
            counted++;
    endtask

    task automatic send_byte(input logic [7:0] value);
        send_request(CMD_BYTE, value);
    endtask

    // tick payload is ignored by the block, so it carries random noise
    task automatic send_tick();
        send_request(CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    // ticks until the held packet times out
    task automatic flush_held();
        while (sb.packet_open)
            send_tick();
    endtask

    // a few ticks, always fewer than the timeout, so the packet stays open
    task automatic short_quiet();
        int limit;
        int n;
        limit = (sb.idle_limit == 16'd0) ? 1 : int'(sb.idle_limit);
        n = $urandom_range(0, (limit > 4) ? 3 : limit - 1);
        repeat (n) send_tick();
    endtask

    // stop offering, wait for every owed result, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.idle_limit = value;
        cfg_wr_en <= 1'b0;
    endtask

    // random traffic: mostly complete packets, some left open so the next
    // packet extends them, some noise; optionally opens with a full buffer
    task automatic run_traffic(input int target, input bit with_full);
        int goal;
        int kind;
        goal = counted + target;
        if (with_full) begin
            repeat (RAM_DEPTH) begin
                send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0)
                    short_quiet();
            end
            // this byte meets a full buffer, forces the flush and is dropped
            send_byte(8'($urandom_range(0, 255)));
        end
        while (counted < goal) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise: ticks on an empty line, or a stray byte
                if (!sb.packet_open)
                    repeat ($urandom_range(1, 2)) send_tick();
                else
                    send_byte(8'($urandom_range(0, 255)));
            end else if (kind == 1) begin
                // broken sequence: bytes with no closing silence
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom_range(0, 255)));
                    short_quiet();
                end
            end else begin
                // well formed packet closed by a full timeout
                repeat ($urandom_range(1, 6)) begin
                    send_byte(8'($urandom_range(0, 255)));
                    short_quiet();
                end
                flush_held();
            end
        end
        flush_held();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset timeout value keeps the packet open, extreme bytes
        rx_stalls = 1'b1;
        send_byte(8'h00);
        send_byte(8'hFF);
        repeat (3) send_tick();

        // timeout of one, printable window edges on both sides; the held
        // packet grows and closes on the first tick
        write_timeout(16'd1);
        send_byte(8'h1F);
        send_byte(8'h20);
        send_byte(8'h7E);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_tick();
        // tick with nothing held does nothing
        send_request(CMD_TICK, 8'hAA);

        // zero timeout acts as one
        write_timeout(16'd0);
        send_byte(8'h55);
        send_tick();

        // largest timeout; a byte mid-wait restarts the idle count
        write_timeout(16'hFFFF);
        send_byte(8'h7E);
        repeat (3) send_tick();
        send_byte(8'h01);
        repeat (2) send_tick();
        // idle count already at the new, shorter timeout
        write_timeout(16'd2);
        flush_held();

        // random, timeout one, with a long result hold to back up the block
        write_timeout(16'd1);
        tx_gaps      = 1'b1;
        hold_request = 1'b1;
        run_traffic(10, 1'b0);

        // random, short random timeout, opening with a forced flush
        write_timeout(16'($urandom_range(2, 5)));
        run_traffic(70, 1'b1);

        // last part of the run with no idling on either side
        write_timeout(16'd3);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        run_traffic(10, 1'b0);

        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
